// ----- src/imufrd_pkg.sv -----
// shared types and constants for the imu frame receiver and decoder
package imufrd_pkg;

  // payload widths
  localparam int unsigned BYTE_W   = 8;
  localparam int unsigned VALUE_W  = 16;
  localparam int unsigned TEMP_W   = 15;
  localparam int unsigned YAW_W    = 32;
  localparam int unsigned CFG_W    = 16;
  localparam int unsigned CFG_IDX_W = 1;

  // bytes of a frame that carry data: header, type and four words
  localparam int unsigned STORE_LEN = 10;

  // configuration register indexes
  localparam logic [CFG_IDX_W-1:0] REG_HEADER = 1'd0;
  localparam logic [CFG_IDX_W-1:0] REG_WRAP   = 1'd1;

  // reset values of the configuration registers
  localparam logic [BYTE_W-1:0]  HEADER_RESET = 8'h55;
  localparam logic [VALUE_W-1:0] WRAP_RESET   = 16'd54613;

  // frame type codes
  localparam logic [BYTE_W-1:0] TYPE_ACCEL = 8'h51;
  localparam logic [BYTE_W-1:0] TYPE_ANGLE = 8'h53;

  // result kind codes
  localparam logic FK_ACCEL = 1'b0;
  localparam logic FK_ANGLE = 1'b1;

  // temperature: raw*100/340 = raw*5/17, done as magnitude * round_up(5*2^22/17) >> 22
  localparam int unsigned TEMP_SHIFT  = 22;
  localparam int unsigned TEMP_MULT_W = 21;
  localparam logic [TEMP_MULT_W-1:0] TEMP_MULT = 21'd1233619;
  localparam int unsigned TEMP_Q_W    = 14;
  localparam logic signed [TEMP_W-1:0] TEMP_OFFSET = 15'sd2100;

  // yaw unwrap
  localparam int unsigned DELTA_W = 18;
  localparam logic signed [DELTA_W-1:0] YAW_TURN = 18'sd65536;

endpackage

// ----- src/imufrd_if.sv -----
// valid/ready channel interfaces for received bytes and decoded results
interface imufrd_rx_if;
  logic                          valid;
  logic                          ready;
  logic [imufrd_pkg::BYTE_W-1:0] rx_byte;

  modport source (output valid, output rx_byte, input ready);
  modport sink   (input valid, input rx_byte, output ready);
endinterface

interface imufrd_res_if;
  logic                                  valid;
  logic                                  ready;
  logic                                  frame_kind;
  logic signed [imufrd_pkg::VALUE_W-1:0] value_x;
  logic signed [imufrd_pkg::VALUE_W-1:0] value_y;
  logic signed [imufrd_pkg::VALUE_W-1:0] value_z;
  logic signed [imufrd_pkg::TEMP_W-1:0]  temperature_centi;
  logic signed [imufrd_pkg::YAW_W-1:0]   yaw_continuous;

  modport source (output valid, output frame_kind, output value_x, output value_y,
                  output value_z, output temperature_centi, output yaw_continuous,
                  input ready);
  modport sink   (input valid, input frame_kind, input value_x, input value_y,
                  input value_z, input temperature_centi, input yaw_continuous,
                  output ready);
endinterface

// ----- src/imu_frame_receiver_decoder.sv -----
// imu serial frame receiver: frame assembly, decode, temperature scaling, yaw unwrap
//
// Usage
//   rx  : one received serial byte per word (valid/ready). Bytes are collected
//         into frames of FRAME_LEN bytes that start with the header byte; a byte
//         that would start a frame without the header is dropped.
//   res : one word per acceleration (type 0x51) or angle (type 0x53) frame, with
//         the three raw words, temperature in hundredths of a degree and the
//         unwrapped yaw count. Other frame types give nothing.
//   cfg : cfg_we / cfg_index / cfg_wdata, index 0 header byte, index 1 yaw wrap
//         threshold. Write only while the block is idle.
// Throughput: one byte per cycle while rx.ready is high. Path: the result of a frame
//   passes the decode register, the multiply and unwrap register and the output
//   register, in that order, after its last byte is accepted.
// Stalls: bytes keep flowing while a result waits; up to three decoded frames
//   are held in the pipe, and only the last byte of a further frame waits for
//   room in the decode register.
// Reset: frame assembly restarts, the yaw history and accumulator clear and the
//   registers return to header 0x55 and threshold 54613.
module imu_frame_receiver_decoder #(
  parameter int unsigned FRAME_LEN = 11
) (
  input  logic                                clk,
  input  logic                                rst,
  imufrd_rx_if.sink                           rx,
  imufrd_res_if.source                        res,
  input  logic                                cfg_we,
  input  logic [imufrd_pkg::CFG_IDX_W-1:0]    cfg_index,
  input  logic [imufrd_pkg::CFG_W-1:0]        cfg_wdata
);
  import imufrd_pkg::*;

  localparam int unsigned CNT_W = $clog2(FRAME_LEN);

  // configuration registers
  logic [BYTE_W-1:0]  header_byte;
  logic [VALUE_W-1:0] wrap_threshold;

  // frame assembly
  logic [BYTE_W-1:0] frame_store [STORE_LEN];
  logic [CNT_W-1:0]  byte_count;
  logic [CNT_W-1:0]  byte_count_next;
  logic [BYTE_W-1:0] view [STORE_LEN];
  logic              in_fire;
  logic              last_byte;
  logic              hdr_ok;
  logic              is_accel;
  logic              is_angle;
  logic              d_load;

  // decode stage
  logic                      d_valid;
  logic                      d_kind;
  logic signed [VALUE_W-1:0] d_x;
  logic signed [VALUE_W-1:0] d_y;
  logic signed [VALUE_W-1:0] d_z;
  logic signed [VALUE_W-1:0] d_t;

  // multiply / unwrap stage
  logic                      m_valid;
  logic                      m_kind;
  logic signed [VALUE_W-1:0] m_x;
  logic signed [VALUE_W-1:0] m_y;
  logic signed [VALUE_W-1:0] m_z;
  logic                      m_neg;
  logic [TEMP_Q_W-1:0]       m_q;
  logic signed [DELTA_W-1:0] m_delta;

  // yaw history
  logic signed [VALUE_W-1:0] previous_yaw;
  logic signed [YAW_W-1:0]   yaw_acc;

  // output register
  logic o_valid;

  // handshake across the stages
  logic o_load;
  logic m_adv;
  logic m_free;
  logic d_adv;
  logic d_free;

  // stage combinational values
  logic [VALUE_W-1:0]                 t_mag;
  logic [VALUE_W+TEMP_MULT_W-1:0]     t_prod;
  logic signed [VALUE_W:0]            y_diff;
  logic [VALUE_W:0]                   y_mag;
  logic signed [DELTA_W-1:0]          y_delta;
  logic signed [TEMP_W-1:0]           q_s;
  logic signed [TEMP_W-1:0]           temp_val;
  logic signed [YAW_W:0]              acc_sum;
  logic signed [YAW_W-1:0]            acc_next;

  // configuration writes
  always_ff @(posedge clk) begin
    if (rst) begin
      header_byte    <= HEADER_RESET;
      wrap_threshold <= WRAP_RESET;
    end else if (cfg_we) begin
      case (cfg_index)
        REG_HEADER: header_byte    <= cfg_wdata[BYTE_W-1:0];
        REG_WRAP:   wrap_threshold <= cfg_wdata[VALUE_W-1:0];
        default:    ;
      endcase
    end
  end

  // pipeline flow control
  always_comb begin
    o_load = !o_valid || res.ready;
    m_adv  = m_valid && o_load;
    m_free = !m_valid || o_load;
    d_adv  = d_valid && m_free;
    d_free = !d_valid || m_free;
  end

  // frame view with the incoming byte in its slot
  always_comb begin
    for (int i = 0; i < STORE_LEN; i++) begin
      view[i] = (byte_count == CNT_W'(i)) ? rx.rx_byte : frame_store[i];
    end
    last_byte = (byte_count == CNT_W'(FRAME_LEN - 1));
    rx.ready  = !last_byte || d_free;
    in_fire   = rx.valid && rx.ready;
    hdr_ok    = (view[0] == header_byte);
    is_accel  = (view[1] == TYPE_ACCEL);
    is_angle  = (view[1] == TYPE_ANGLE);
    d_load    = in_fire && hdr_ok && last_byte && (is_accel || is_angle);
    if (!in_fire) begin
      byte_count_next = byte_count;
    end else if (!hdr_ok || last_byte) begin
      byte_count_next = '0;
    end else begin
      byte_count_next = byte_count + 1'b1;
    end
  end

  // byte store and count
  always_ff @(posedge clk) begin
    if (rst) begin
      byte_count <= '0;
    end else begin
      byte_count <= byte_count_next;
    end
    for (int i = 0; i < STORE_LEN; i++) begin
      if (in_fire && byte_count == CNT_W'(i)) begin
        frame_store[i] <= rx.rx_byte;
      end
    end
  end

  // decode register
  always_ff @(posedge clk) begin
    if (rst) begin
      d_valid <= 1'b0;
    end else if (d_load) begin
      d_valid <= 1'b1;
    end else if (d_adv) begin
      d_valid <= 1'b0;
    end
    if (d_load) begin
      d_kind <= is_angle ? FK_ANGLE : FK_ACCEL;
      d_x    <= {view[3], view[2]};
      d_y    <= {view[5], view[4]};
      d_z    <= {view[7], view[6]};
      d_t    <= {view[9], view[8]};
    end
  end

  // temperature multiply and yaw step
  always_comb begin
    t_mag  = d_t[VALUE_W-1] ? VALUE_W'(-d_t) : VALUE_W'(d_t);
    t_prod = (VALUE_W+TEMP_MULT_W)'(t_mag) * (VALUE_W+TEMP_MULT_W)'(TEMP_MULT);
    y_diff = (VALUE_W+1)'(d_z) - (VALUE_W+1)'(previous_yaw);
    y_mag  = y_diff[VALUE_W] ? (VALUE_W+1)'(-y_diff) : (VALUE_W+1)'(y_diff);
    if (y_mag > {1'b0, wrap_threshold}) begin
      if (d_z[VALUE_W-1]) begin
        y_delta = YAW_TURN - $signed(DELTA_W'(y_mag));
      end else begin
        y_delta = $signed(DELTA_W'(y_mag)) - YAW_TURN;
      end
    end else begin
      y_delta = DELTA_W'(y_diff);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      m_valid      <= 1'b0;
      previous_yaw <= '0;
    end else begin
      if (d_adv) begin
        m_valid <= 1'b1;
      end else if (m_adv) begin
        m_valid <= 1'b0;
      end
      if (d_adv && d_kind == FK_ANGLE) begin
        previous_yaw <= d_z;
      end
    end
    if (d_adv) begin
      m_kind  <= d_kind;
      m_x     <= d_x;
      m_y     <= d_y;
      m_z     <= d_z;
      m_neg   <= d_t[VALUE_W-1];
      m_q     <= t_prod[TEMP_SHIFT +: TEMP_Q_W];
      m_delta <= y_delta;
    end
  end

  // temperature offset and saturating accumulate
  always_comb begin
    q_s      = $signed(TEMP_W'(m_q));
    temp_val = (m_neg ? -q_s : q_s) + TEMP_OFFSET;
    acc_sum  = (YAW_W+1)'(yaw_acc) + (YAW_W+1)'(m_delta);
    if (acc_sum[YAW_W] != acc_sum[YAW_W-1]) begin
      acc_next = acc_sum[YAW_W] ? {1'b1, {(YAW_W-1){1'b0}}} : {1'b0, {(YAW_W-1){1'b1}}};
    end else begin
      acc_next = acc_sum[YAW_W-1:0];
    end
  end

  // output register and accumulator
  always_ff @(posedge clk) begin
    if (rst) begin
      o_valid <= 1'b0;
      yaw_acc <= '0;
    end else begin
      if (m_adv) begin
        o_valid <= 1'b1;
      end else if (res.ready) begin
        o_valid <= 1'b0;
      end
      if (m_adv && m_kind == FK_ANGLE) begin
        yaw_acc <= acc_next;
      end
    end
    if (m_adv) begin
      res.frame_kind        <= m_kind;
      res.value_x           <= m_x;
      res.value_y           <= m_y;
      res.value_z           <= m_z;
      res.temperature_centi <= temp_val;
      res.yaw_continuous    <= (m_kind == FK_ANGLE) ? acc_next : yaw_acc;
    end
  end

  assign res.valid = o_valid;

  // the byte count never reaches a full frame
  a_count_range: assert property (@(posedge clk) disable iff (rst)
    byte_count < CNT_W'(FRAME_LEN))
    else $error("byte count out of range");

  // input only waits on the last byte of a frame
  a_ready_last: assert property (@(posedge clk) disable iff (rst)
    !rx.ready |-> last_byte && d_valid && !m_free)
    else $error("input stalled outside a frame end");

  // accumulator moves only when an angle frame reaches the output
  a_acc_stable: assert property (@(posedge clk) disable iff (rst)
    !(m_adv && m_kind == FK_ANGLE) |=> $stable(yaw_acc))
    else $error("yaw accumulator changed without an angle frame");

  // yaw history moves only when an angle frame leaves the decode register
  a_prev_stable: assert property (@(posedge clk) disable iff (rst)
    !(d_adv && d_kind == FK_ANGLE) |=> $stable(previous_yaw))
    else $error("previous yaw changed without an angle frame");

  // a waiting decoded frame is not lost
  a_d_hold: assert property (@(posedge clk) disable iff (rst)
    d_valid && !m_free |=> d_valid)
    else $error("decoded frame dropped while stalled");

endmodule
